// File: rtl/core/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
`timescale 1ns / 1ps

package rbd_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int ELEMENT_BITS_DEF = 32;
	localparam int OP_W             = 3;
	localparam int STATUS_W         = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-item outcome handed from the controller to the result pipeline.
	typedef struct packed {
		status_t status;
		logic    use_rd;
	} result_t;

endpackage

// File: rtl/core/ring_buffer_deque.sv
// An accepted item's result is held in the stage-one registers (result_s1, count_s1 and the
// store's read data), then in the output register that drives the master side.
// Throughput: one item per cycle while the output register can advance; pointer update and the
// store access happen in the same cycle, and the read data of the single read port is registered.
// Reset clears the head and tail pointers, the count and the result pipeline.
// The element store is not cleared; its entries are only read after being written.
`timescale 1ns / 1ps

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
	localparam int AW          = $clog2(DEPTH),
	localparam int CW          = $clog2(DEPTH + 1),
	localparam int IN_TW       = ((OP_W + ELEMENT_BITS + 7) / 8) * 8,
	localparam int OUT_TW      = ((STATUS_W + ELEMENT_BITS + CW + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // operation, data_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata   // status, data_out, element_count
);

	logic                    accept;
	logic [OP_W-1:0]         operation;
	logic [ELEMENT_BITS-1:0] data_in;
	logic                    wr_en, rd_en;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic [ELEMENT_BITS-1:0] rd_data;
	result_t                 result;
	logic [CW-1:0]           count_nxt;

	logic                    valid_s1;
	result_t                 result_s1;
	logic [CW-1:0]           count_s1;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [ELEMENT_BITS-1:0] out_data_q;
	logic [CW-1:0]           out_count_q;
	logic                    out_free, advance;

	assign operation = s_tdata[OP_W-1:0];
	assign data_in   = s_tdata[OP_W +: ELEMENT_BITS];

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	// A new item may enter when no item is in flight or the item in flight can move on to the output register.
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	rbd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.result    (result),
		.count_nxt (count_nxt)
	);

	rbd_mem #(.DEPTH(DEPTH), .WIDTH(ELEMENT_BITS)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (data_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
			count_s1  <= count_nxt;
		end
		if (advance) begin
			out_status_q <= result_s1.status;
			out_data_q   <= result_s1.use_rd ? rd_data : '0;
			out_count_q  <= count_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'({out_count_q, out_data_q, out_status_q});

endmodule

// File: rtl/core/rbd_mem.sv
// Element store: single-port write, single-port read, registered read data.
`timescale 1ns / 1ps

module rbd_mem #(
	parameter int DEPTH = rbd_pkg::DEPTH_DEF,
	parameter int WIDTH = rbd_pkg::ELEMENT_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/rbd_ctrl.sv
// Head, tail and count registers with the operation decode that drives the store.
`timescale 1ns / 1ps

module rbd_ctrl
	import rbd_pkg::*;
#(
	parameter int DEPTH = rbd_pkg::DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [OP_W-1:0] operation,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	output result_t         result,
	output logic [CW-1:0]   count_nxt
);

	logic [AW-1:0] head_q, tail_q, head_nxt, tail_nxt;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic          full, empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign tail_dec = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - AW'(1);

	always_comb begin
		head_nxt      = head_q;
		tail_nxt      = tail_q;
		count_nxt     = count_q;
		wr_en         = 1'b0;
		wr_addr       = tail_inc;
		rd_en         = 1'b0;
		rd_addr       = head_q;
		result.status = ST_OK;
		result.use_rd = 1'b0;
		if (accept) begin
			unique case (op_t'(operation))
				OP_PUSH_BACK, OP_PUSH_FRONT: begin
					if (full) begin
						result.status = ST_FULL;
					end else begin
						wr_en     = 1'b1;
						count_nxt = count_q + CW'(1);
						// The first element of an empty queue always lands in entry zero.
						if (empty) begin
							head_nxt = '0;
							tail_nxt = '0;
							wr_addr  = '0;
						end else if (op_t'(operation) == OP_PUSH_BACK) begin
							tail_nxt = tail_inc;
							wr_addr  = tail_inc;
						end else begin
							head_nxt = head_dec;
							wr_addr  = head_dec;
						end
					end
				end
				OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
					if (empty) begin
						result.status = ST_EMPTY;
					end else begin
						rd_en         = 1'b1;
						result.use_rd = 1'b1;
						if (op_t'(operation) == OP_POP_BACK
							|| op_t'(operation) == OP_PEEK_BACK) begin
							rd_addr = tail_q;
						end
						if (op_t'(operation) == OP_POP_FRONT
							|| op_t'(operation) == OP_POP_BACK) begin
							count_nxt = count_q - CW'(1);
							if (count_q == CW'(1)) begin
								head_nxt = '0;
								tail_nxt = '0;
							end else if (op_t'(operation) == OP_POP_FRONT) begin
								head_nxt = head_inc;
							end else begin
								tail_nxt = tail_dec;
							end
						end
					end
				end
				OP_CLEAR: begin
					head_nxt  = '0;
					tail_nxt  = '0;
					count_nxt = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

// File: rtl/core/rbd_checker.sv
// Port-level assertions for the ring buffer deque, bound to the top level.
`timescale 1ns / 1ps

module rbd_checker
	import rbd_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
	localparam int CW          = $clog2(DEPTH + 1),
	localparam int OUT_TW      = ((STATUS_W + ELEMENT_BITS + CW + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata
);

	logic [STATUS_W-1:0]     status;
	logic [ELEMENT_BITS-1:0] data_out;
	logic [CW-1:0]           element_count;

	assign status        = m_tdata[STATUS_W-1:0];
	assign data_out      = m_tdata[STATUS_W +: ELEMENT_BITS];
	assign element_count = m_tdata[STATUS_W + ELEMENT_BITS +: CW];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result item changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == ST_FULL |-> element_count == CW'(DEPTH) && data_out == '0)
		else $error("full status without a full queue");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == ST_EMPTY |-> element_count == '0 && data_out == '0)
		else $error("empty status without an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> element_count <= CW'(DEPTH))
		else $error("element count beyond depth");

endmodule

bind ring_buffer_deque rbd_checker #(
	.DEPTH        (DEPTH),
	.ELEMENT_BITS (ELEMENT_BITS)
) u_rbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ring buffer deque: queued operations in, predicted results out.

module tb;
	import rbd_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int ELEM_W     = ELEMENT_BITS_DEF;
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int IN_TW      = ((OP_W + ELEM_W + 7) / 8) * 8;
	localparam int OUT_TW     = ((STATUS_W + ELEM_W + CW + 7) / 8) * 8;
	localparam int RANDOM_OPS = 510;
	localparam int SETTLE_CYC = 6;
	localparam int MAX_REPORTS = 10;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam logic [ELEM_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ELEM_W-1:0] value;
	} deque_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ELEM_W-1:0]   value;
		logic [CW-1:0]       count;
	} deque_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata = '0;   // operation, data_in
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;        // status, data_out, element_count

	deque_op_t     pending_ops[$];
	deque_result_t expected_results[$];
	deque_op_t     cur_op;
	int            total_ops = 0;
	int            ops_taken = 0;
	int            mismatches = 0;

	// Shadow of the deque contents.
	logic [ELEM_W-1:0] shadow_store[DEPTH];
	int                front_idx = 0;
	int                back_idx = 0;
	int                fill = 0;

	ring_buffer_deque dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic int idx_inc(int p);
		return (p == DEPTH - 1) ? 0 : p + 1;
	endfunction

	function automatic int idx_dec(int p);
		return (p == 0) ? DEPTH - 1 : p - 1;
	endfunction

	function automatic deque_result_t apply_op(deque_op_t it);
		deque_result_t r;
		r.status = ST_OK;
		r.value  = '0;
		case (it.op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (fill == 0) begin
						front_idx = 0;
						back_idx  = 0;
					end else if (it.op == OP_PUSH_BACK) begin
						back_idx = idx_inc(back_idx);
					end else begin
						front_idx = idx_dec(front_idx);
					end
					shadow_store[(it.op == OP_PUSH_BACK) ? back_idx : front_idx] = it.value;
					fill++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (it.op == OP_POP_FRONT || it.op == OP_PEEK_FRONT)
						r.value = shadow_store[front_idx];
					else
						r.value = shadow_store[back_idx];
					if (it.op == OP_POP_FRONT || it.op == OP_POP_BACK) begin
						fill--;
						// An emptied queue starts over at entry 0.
						if (fill == 0) begin
							front_idx = 0;
							back_idx  = 0;
						end else if (it.op == OP_POP_FRONT) begin
							front_idx = idx_inc(front_idx);
						end else begin
							back_idx = idx_dec(back_idx);
						end
					end
				end
			end
			OP_CLEAR: begin
				front_idx = 0;
				back_idx  = 0;
				fill      = 0;
			end
			default: begin
			end
		endcase
		r.count = fill[CW-1:0];
		return r;
	endfunction

	// Traffic shaping: receiver-heavy stalling first, then sender-heavy idling, then none.
	function automatic int send_idle_pct();
		if (ops_taken < total_ops / 3)
			return 30;
		else if (ops_taken < 2 * total_ops / 3)
			return 53;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (ops_taken < total_ops / 3)
			return 53;
		else if (ops_taken < 2 * total_ops / 3)
			return 30;
		return 0;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return ALL_ONES;
		return $urandom;
	endfunction

	task automatic add_op(logic [OP_W-1:0] op, logic [ELEM_W-1:0] value);
		deque_op_t it;
		it.op    = op;
		it.value = value;
		pending_ops.push_back(it);
	endtask

	task automatic check_field(string name, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch in %s at %0t: expected %h, got %h", name, $time, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_op(cur_op));
				ops_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
					cur_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= IN_TW'({cur_op.value, cur_op.op});
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		deque_result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[STATUS_W-1:0];
				got.value  = m_tdata[STATUS_W +: ELEM_W];
				got.count  = m_tdata[STATUS_W + ELEM_W +: CW];
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result at %0t: %h", $time, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("status", ELEM_W'(want.status), ELEM_W'(got.status));
					check_field("data_out", want.value, got.value);
					check_field("element_count", ELEM_W'(want.count), ELEM_W'(got.count));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
		end
	end

	initial begin
		int mode;
		int burst;
		int r;
		int made;

		// Directed part: empty rejects, extreme values, every operation, fill to full.
		add_op(OP_POP_FRONT, ALL_ONES);
		add_op(OP_PUSH_BACK, '0);
		add_op(OP_PUSH_FRONT, ALL_ONES);
		add_op(OP_PEEK_FRONT, '0);
		add_op(OP_PEEK_BACK, '0);
		add_op(OP_UNUSED, ALL_ONES);
		add_op(OP_POP_BACK, '0);
		add_op(OP_POP_FRONT, '0);
		for (int i = 0; i < DEPTH; i++)
			add_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
		add_op(OP_PUSH_BACK, ALL_ONES);
		add_op(OP_CLEAR, ALL_ONES);
		add_op(OP_PEEK_BACK, '0);

		// Random part in bursts that lean toward filling, draining or neither.
		made = 0;
		while (made < RANDOM_OPS) begin
			mode  = $urandom_range(0, 2);
			burst = $urandom_range(8, 40);
			for (int i = 0; i < burst; i++) begin
				r = $urandom_range(0, 99);
				if (mode == 0)
					r = (r < 70) ? r * 40 / 70 : 40 + (r - 70) * 60 / 30;
				else if (mode == 1)
					r = (r < 15) ? r * 40 / 15 : 40 + (r - 15) * 60 / 85;
				if (r < 40)
					add_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value());
				else if (r < 70)
					add_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, rand_value());
				else if (r < 95)
					add_op($urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_BACK, rand_value());
				else if (r < 98)
					add_op(OP_UNUSED, rand_value());
				else
					add_op(OP_CLEAR, rand_value());
				made++;
			end
		end
		total_ops = pending_ops.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_taken < total_ops || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/rbd_pkg.sv
rtl/core/rbd_mem.sv
rtl/core/rbd_ctrl.sv
rtl/core/ring_buffer_deque.sv
rtl/core/rbd_checker.sv
test/tb.sv
